[rtl/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define TSSPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define TSSPA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

[rtl/tsspa_pkg.sv]
// Shared types, constants and helpers for the two-sided stack pool allocator.
// No dependencies; imported by the cell, chain and top modules and the testbench.
package tsspa_pkg;

  localparam int ADDR_W                     = 24;
  localparam int CNT_MAX_W                  = 11;
  localparam int DEFAULT_MAX_BLOCKS         = 64;
  localparam int DEFAULT_MAX_SAVED          = 16;
  localparam int DEFAULT_STATE_RECORD_BYTES = 16;

  localparam logic [ADDR_W-1:0] HDR_BYTES      = 24'd8;
  localparam logic [ADDR_W-1:0] ALIGN_MINUS1   = 24'd15;
  localparam logic [ADDR_W-1:0] MAX_ROUNDABLE  = 24'hFFFFF0;
  localparam logic [ADDR_W-1:0] RST_POOL_START = 24'h000000;
  localparam logic [ADDR_W-1:0] RST_POOL_END   = 24'h100000;
  localparam logic [ADDR_W-1:0] RST_FREE       = 24'h0FFFF0;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_FREE    = 3'd2,
    OP_REALLOC = 3'd3,
    OP_AVAIL   = 3'd4,
    OP_PUSH    = 3'd5,
    OP_POP     = 3'd6,
    OP_NONE    = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_STACK     = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_POOL_START = 1'b0,
    REG_POOL_END   = 1'b1
  } cfg_reg_e;

  // Search token that walks the cell chain one cell per cycle.
  typedef struct packed {
    logic                 active;
    logic                 right;
    logic [ADDR_W-1:0]    key;
    logic [CNT_MAX_W-1:0] limit;
    logic                 found;
    logic [CNT_MAX_W-1:0] idx;
    logic [ADDR_W-1:0]    upper;
    logic [CNT_MAX_W-1:0] top_pos;
    logic [ADDR_W-1:0]    top;
  } token_t;

  // Table write broadcast to all cells.
  typedef struct packed {
    logic                 left_en;
    logic                 right_en;
    logic [CNT_MAX_W-1:0] idx;
    logic [ADDR_W-1:0]    left_start;
    logic [ADDR_W-1:0]    right_start;
    logic [ADDR_W-1:0]    right_upper;
  } wr_t;

  // Round a 24-bit address up to a multiple of 16, wrapping at 2^24.
  function automatic logic [ADDR_W-1:0] round16(input logic [ADDR_W-1:0] x);
    logic [ADDR_W:0] t;
    t = {1'b0, x} + {1'b0, ALIGN_MINUS1};
    return {t[ADDR_W-1:4], 4'b0000};
  endfunction

endpackage

[rtl/tsspa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the saved-state stack.
module tsspa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/tsspa_cell.sv]
// One block-table cell: holds a left start and a right start/upper pair.
// Depends on tsspa_pkg; instantiated in a row by tsspa_chain.
module tsspa_cell
  import tsspa_pkg::*;
#(
  parameter int CellIndex = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  wr_t    wr_i,
  input  token_t tok_i,
  output token_t tok_o
);

  localparam logic [CNT_MAX_W-1:0] MyIdx = CNT_MAX_W'(CellIndex);

  logic [ADDR_W-1:0] left_start_q, right_start_q, right_upper_q;
  token_t            tok_d, tok_q;
  logic              hit;

  // Table entry update from the broadcast write.
  always_ff @(posedge clk_i) begin
    if (wr_i.left_en && wr_i.idx == MyIdx) begin
      left_start_q <= wr_i.left_start;
    end
    if (wr_i.right_en && wr_i.idx == MyIdx) begin
      right_start_q <= wr_i.right_start;
      right_upper_q <= wr_i.right_upper;
    end
  end

  // Compare the passing token against this entry; the first live match wins.
  always_comb begin
    hit   = tok_i.right ? (right_start_q == tok_i.key) : (left_start_q == tok_i.key);
    tok_d = tok_i;
    if (tok_i.active && !tok_i.found && (MyIdx < tok_i.limit) && hit) begin
      tok_d.found = 1'b1;
      tok_d.idx   = MyIdx;
      tok_d.upper = right_upper_q;
    end
    if (tok_i.active && tok_i.top_pos == MyIdx) begin
      tok_d.top = left_start_q;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[rtl/tsspa_chain.sv]
// Row of block-table cells through which a search token travels.
// Depends on tsspa_pkg and tsspa_cell.
module tsspa_chain
  import tsspa_pkg::*;
#(
  parameter int MaxBlocks = DEFAULT_MAX_BLOCKS
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  wr_t    wr_i,
  input  token_t tok_i,
  output token_t tok_o
);

  token_t link [MaxBlocks+1];

  assign link[0] = tok_i;

  // Cells in a row, each feeding its neighbor.
  for (genvar g = 0; g < MaxBlocks; g++) begin : g_cell
    tsspa_cell #(
      .CellIndex(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .wr_i  (wr_i),
      .tok_i (link[g]),
      .tok_o (link[g+1])
    );
  end

  assign tok_o = link[MaxBlocks];

endmodule

[rtl/two_sided_stack_pool_allocator.sv]
// Top level of the two-sided stack pool allocator.
// Depends on tsspa_pkg, tsspa_chain, tsspa_ram and assert_macros.svh.
//
// Usage: commands arrive on the s_axis channel (opcode and side in tuser,
// request size and block address in tdata); one result per command leaves
// on the m_axis channel (addresses in tdata, status in tuser). Pool bounds
// are set over the APB port and take effect at the next init command.
// Init, alloc, available and push need no wait state: the result is
// registered at the accepting edge. Pop waits in a state for the registered
// read of the saved-state RAM. Free and realloc wait for the search token
// walking the chain of block cells; realloc then allocates in its own state.
// One command is in flight at a time; a new one is taken only when the
// output register is empty or being drained in the same cycle.
// Reset performs an init with the reset pool bounds and empties the saved
// stack. A stall on m_axis holds the result and blocks new commands.
`include "assert_macros.svh"

module two_sided_stack_pool_allocator
  import tsspa_pkg::*;
#(
  parameter int MaxBlocks        = DEFAULT_MAX_BLOCKS,
  parameter int MaxSaved         = DEFAULT_MAX_SAVED,
  parameter int StateRecordBytes = DEFAULT_STATE_RECORD_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command transactions: tdata = request_size, block_address.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // tuser = opcode[2:0], side[3].
  input  logic [3:0]  s_axis_tuser,
  // Result transactions: tdata = result_address, free_bytes.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  // tuser = status[1:0].
  output logic [1:0]  m_axis_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W  = $clog2(MaxBlocks + 1);
  localparam int SV_W   = $clog2(MaxSaved + 1);
  localparam int SA_W   = (MaxSaved > 1) ? $clog2(MaxSaved) : 1;
  localparam int SNAP_W = 3 * ADDR_W + 2 * CNT_W;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SEARCH  = 4'b0010,
    S_REALLOC = 4'b0100,
    S_POP     = 4'b1000
  } state_e;

  state_e            state_d, state_q;
  logic [ADDR_W-1:0] cfg_start_q, cfg_end_q;
  logic [ADDR_W-1:0] lhead_d, lhead_q, rhead_d, rhead_q, free_d, free_q;
  logic [CNT_W-1:0]  lcnt_d, lcnt_q, rcnt_d, rcnt_q;
  logic [SV_W-1:0]   scnt_d, scnt_q, scnt_m1;
  opcode_e           op_d, op_q;
  logic [ADDR_W-1:0] req_d, req_q;
  logic              out_valid_d, out_valid_q;
  logic [ADDR_W-1:0] out_addr_d, out_addr_q, out_free_d, out_free_q;
  status_e           out_status_d, out_status_q;

  opcode_e           in_op;
  logic              in_side, in_fire, cfg_wr;
  logic [ADDR_W-1:0] in_req, in_user;

  // Init values from the configuration registers.
  logic [ADDR_W-1:0] i_start, i_end, i_free;
  logic [ADDR_W:0]   i_min_end;

  // Shared allocation unit.
  logic [ADDR_W-1:0] a_req;
  logic              a_side, a_fail;
  logic [ADDR_W:0]   a_size, a_need;
  logic [ADDR_W-1:0] a_lhead, a_rhead, a_free, a_addr;

  token_t            tok_in, tok_out;
  wr_t               wr;
  logic [ADDR_W-1:0] srch_key;
  logic              top_ok;

  logic              ram_we, ram_re;
  logic [SNAP_W-1:0] ram_wdata, ram_rdata;

  logic              emit, emit_avail;
  logic [ADDR_W-1:0] emit_addr;
  status_e           emit_status;

  assign in_op   = opcode_e'(s_axis_tuser[2:0]);
  assign in_side = s_axis_tuser[3];
  assign in_req  = s_axis_tdata[23:0];
  assign in_user = s_axis_tdata[47:24];

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q <= RST_POOL_START;
      cfg_end_q   <= RST_POOL_END;
    end else if (cfg_wr) begin
      if (cfg_reg_e'(paddr[2]) == REG_POOL_END) begin
        cfg_end_q <= pwdata[ADDR_W-1:0];
      end else begin
        cfg_start_q <= pwdata[ADDR_W-1:0];
      end
    end
  end

  assign prdata = (cfg_reg_e'(paddr[2]) == REG_POOL_END) ? {8'd0, cfg_end_q}
                                                          : {8'd0, cfg_start_q};

  // Pool bounds as an init command sees them.
  always_comb begin
    i_start   = round16(cfg_start_q);
    i_end     = round16(cfg_end_q - ALIGN_MINUS1);
    i_min_end = {1'b0, i_start} + (ADDR_W+1)'(16);
    i_free    = ({1'b0, i_end} >= i_min_end) ? (i_end - i_start - ADDR_W'(16)) : '0;
  end

  // Allocation operands: the live command in idle, the stored request after a free.
  always_comb begin
    if (state_q == S_REALLOC) begin
      a_req  = req_q;
      a_side = 1'b0;
    end else begin
      a_req  = (in_op == OP_PUSH) ? ADDR_W'(StateRecordBytes) : in_req;
      a_side = (in_op == OP_ALLOC) ? in_side : 1'b0;
    end
  end

  // Size, space check and new heads for one allocation.
  always_comb begin
    a_size  = (a_req > MAX_ROUNDABLE) ? {1'b1, {ADDR_W{1'b0}}} : {1'b0, round16(a_req)};
    a_need  = a_size + {1'b0, HDR_BYTES};
    a_fail  = ({1'b0, free_q} < a_need) ||
              (a_side ? (rcnt_q >= CNT_W'(MaxBlocks)) : (lcnt_q >= CNT_W'(MaxBlocks)));
    a_lhead = lhead_q + a_need[ADDR_W-1:0];
    a_rhead = rhead_q - a_need[ADDR_W-1:0];
    a_free  = free_q - a_need[ADDR_W-1:0];
    a_addr  = a_side ? (a_rhead + HDR_BYTES) : (lhead_q + HDR_BYTES);
  end

  assign scnt_m1   = scnt_q - SV_W'(1);
  assign srch_key  = tok_out.key;
  assign top_ok    = (lcnt_q != '0) && (tok_out.top == srch_key);
  assign ram_wdata = {lcnt_q, rcnt_q, rhead_q, lhead_q, free_q};

  // Command sequencing and state update.
  always_comb begin
    state_d     = state_q;
    lhead_d     = lhead_q;
    rhead_d     = rhead_q;
    free_d      = free_q;
    lcnt_d      = lcnt_q;
    rcnt_d      = rcnt_q;
    scnt_d      = scnt_q;
    op_d        = op_q;
    req_d       = req_q;
    tok_in      = '0;
    wr          = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    emit        = 1'b0;
    emit_avail  = 1'b0;
    emit_addr   = '0;
    emit_status = STAT_OK;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d  = in_op;
          req_d = in_req;
          case (in_op)
            OP_INIT: begin
              lhead_d = i_start;
              rhead_d = i_end;
              free_d  = i_free;
              lcnt_d  = '0;
              rcnt_d  = '0;
              scnt_d  = '0;
              emit    = 1'b1;
            end
            OP_ALLOC, OP_PUSH: begin
              emit = 1'b1;
              if (in_op == OP_PUSH && scnt_q >= SV_W'(MaxSaved)) begin
                emit_status = STAT_STACK;
              end else if (a_fail) begin
                emit_status = STAT_NO_SPACE;
              end else begin
                emit_addr = a_addr;
                free_d    = a_free;
                wr.idx    = CNT_MAX_W'(a_side ? rcnt_q : lcnt_q);
                if (a_side) begin
                  rhead_d        = a_rhead;
                  rcnt_d         = rcnt_q + CNT_W'(1);
                  wr.right_en    = 1'b1;
                  wr.right_start = a_rhead;
                  wr.right_upper = rhead_q;
                end else begin
                  lhead_d       = a_lhead;
                  lcnt_d        = lcnt_q + CNT_W'(1);
                  wr.left_en    = 1'b1;
                  wr.left_start = lhead_q;
                end
                if (in_op == OP_PUSH) begin
                  ram_we = 1'b1;
                  scnt_d = scnt_q + SV_W'(1);
                end
              end
            end
            OP_FREE, OP_REALLOC: begin
              tok_in.active  = 1'b1;
              tok_in.key     = in_user - HDR_BYTES;
              tok_in.right   = (tok_in.key >= lhead_q);
              tok_in.limit   = CNT_MAX_W'(tok_in.right ? rcnt_q : lcnt_q);
              tok_in.top_pos = CNT_MAX_W'(lcnt_q) - CNT_MAX_W'(1);
              state_d        = S_SEARCH;
            end
            OP_AVAIL: begin
              emit       = 1'b1;
              emit_avail = 1'b1;
            end
            OP_POP: begin
              if (scnt_q == '0) begin
                emit        = 1'b1;
                emit_status = STAT_STACK;
              end else begin
                ram_re  = 1'b1;
                state_d = S_POP;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (tok_out.active) begin
          if ((op_q == OP_REALLOC && !top_ok) || !tok_out.found) begin
            emit        = 1'b1;
            emit_status = STAT_NOT_FOUND;
            state_d     = S_IDLE;
          end else begin
            if (tok_out.right) begin
              free_d  = free_q + (tok_out.upper - rhead_q);
              rhead_d = tok_out.upper;
              rcnt_d  = tok_out.idx[CNT_W-1:0];
            end else begin
              free_d  = free_q + (lhead_q - srch_key);
              lhead_d = srch_key;
              lcnt_d  = tok_out.idx[CNT_W-1:0];
            end
            if (op_q == OP_REALLOC) begin
              state_d = S_REALLOC;
            end else begin
              emit    = 1'b1;
              state_d = S_IDLE;
            end
          end
        end
      end
      S_REALLOC: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        if (a_fail) begin
          emit_status = STAT_NO_SPACE;
        end else begin
          emit_addr     = a_addr;
          free_d        = a_free;
          lhead_d       = a_lhead;
          lcnt_d        = lcnt_q + CNT_W'(1);
          wr.left_en    = 1'b1;
          wr.idx        = CNT_MAX_W'(lcnt_q);
          wr.left_start = lhead_q;
        end
      end
      S_POP: begin
        {lcnt_d, rcnt_d, rhead_d, lhead_d, free_d} = ram_rdata;
        scnt_d  = scnt_m1;
        emit    = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Result register: load on completion, otherwise drain on the handshake.
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_addr_d   = out_addr_q;
    out_free_d   = out_free_q;
    out_status_d = out_status_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_addr_d   = emit_addr;
      out_status_d = emit_status;
      if (emit_avail) begin
        out_free_d = (free_q >= HDR_BYTES) ? (free_q - HDR_BYTES) : '0;
      end else begin
        out_free_d = free_d;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lhead_q     <= RST_POOL_START;
      rhead_q     <= RST_POOL_END;
      free_q      <= RST_FREE;
      lcnt_q      <= '0;
      rcnt_q      <= '0;
      scnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lhead_q     <= lhead_d;
      rhead_q     <= rhead_d;
      free_q      <= free_d;
      lcnt_q      <= lcnt_d;
      rcnt_q      <= rcnt_d;
      scnt_q      <= scnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_q        <= req_d;
    out_addr_q   <= out_addr_d;
    out_free_q   <= out_free_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_free_q, out_addr_q};
  assign m_axis_tuser  = out_status_q;

  // Block tables as a chain of cells.
  tsspa_chain #(
    .MaxBlocks(MaxBlocks)
  ) u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .wr_i  (wr),
    .tok_i (tok_in),
    .tok_o (tok_out)
  );

  // Saved-state stack.
  tsspa_ram #(
    .Width(SNAP_W),
    .Depth(MaxSaved)
  ) u_saved (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(scnt_q[SA_W-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(scnt_m1[SA_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // A token leaves the chain only while a search is pending.
  `TSSPA_ASSERT_IMP(a_tok_in_search, tok_out.active, state_q == S_SEARCH,
                    "search token outside search state")
  // Commands are taken only in idle.
  `TSSPA_ASSERT_IMP(a_ready_idle, s_axis_tready, state_q == S_IDLE,
                    "command accepted while busy")
  // Block counts never pass the table depth.
  `TSSPA_ASSERT(a_cnt_bound,
                (lcnt_q <= CNT_W'(MaxBlocks)) && (rcnt_q <= CNT_W'(MaxBlocks)),
                "block count beyond table depth")
  // Saved count never passes the stack depth.
  `TSSPA_ASSERT(a_scnt_bound, scnt_q <= SV_W'(MaxSaved), "saved count beyond stack depth")
  // A pop returns to idle with a result in the next cycle.
  `TSSPA_ASSERT_IMP(a_pop_done, state_q == S_POP, ##1 (state_q == S_IDLE && out_valid_q),
                    "pop did not complete")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the two-sided stack pool allocator.
// Depends on tsspa_pkg and the allocator RTL; predicts every result in SV.
`timescale 1ns / 100ps

module testbench;
  import tsspa_pkg::*;

  localparam int NBLK = 64;
  localparam int NSAVE = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [23:0] addr;
    logic [23:0] free;
    status_e     status;
  } result_t;

  typedef struct {
    logic [23:0] free;
    logic [23:0] lhead;
    logic [23:0] rhead;
    int          lcnt;
    int          rcnt;
  } snapshot_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  two_sided_stack_pool_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicted allocator state and pool registers.
  logic [23:0] cfg_start, cfg_end;
  logic [23:0] lhead, rhead, free_sp;
  logic [23:0] lstarts [NBLK];
  logic [23:0] rstarts [NBLK];
  logic [23:0] ruppers [NBLK];
  int          lcnt, rcnt, scnt;
  snapshot_t   saved [NSAVE];

  result_t pending_results[$];
  int      failures;
  int      send_idle_pct, recv_stall_pct;
  int      quiet_cycles;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [23:0] align16(logic [23:0] x);
    logic [23:0] t;
    t = x + 24'd15;
    return {t[23:4], 4'b0000};
  endfunction

  function automatic void pool_init();
    logic [23:0] s, e;
    s = align16(cfg_start);
    e = align16(cfg_end - 24'd15);
    lhead = s;
    rhead = e;
    free_sp = ({8'd0, e} >= {8'd0, s} + 32'd16) ? e - s - 24'd16 : 24'd0;
    lcnt = 0;
    rcnt = 0;
    scnt = 0;
  endfunction

  function automatic status_e carve_block(logic [23:0] req, logic side,
                                          output logic [23:0] addr);
    logic [24:0] size;
    size = {1'b0, align16(req)};
    if (req > MAX_ROUNDABLE) size = 25'h1000000;
    size = size + 25'd8;
    addr = '0;
    if ({1'b0, free_sp} < size) return STAT_NO_SPACE;
    if (!side) begin
      if (lcnt >= NBLK) return STAT_NO_SPACE;
      lstarts[lcnt] = lhead;
      lcnt++;
      addr = lhead + 24'd8;
      lhead = lhead + size[23:0];
    end else begin
      if (rcnt >= NBLK) return STAT_NO_SPACE;
      ruppers[rcnt] = rhead;
      rhead = rhead - size[23:0];
      rstarts[rcnt] = rhead;
      rcnt++;
      addr = rhead + 24'd8;
    end
    free_sp = free_sp - size[23:0];
    return STAT_OK;
  endfunction

  function automatic status_e release_block(logic [23:0] user);
    logic [23:0] blk;
    blk = user - 24'd8;
    if (blk < lhead) begin
      for (int i = 0; i < lcnt; i++) begin
        if (lstarts[i] == blk) begin
          free_sp = free_sp + (lhead - blk);
          lhead = blk;
          lcnt = i;
          return STAT_OK;
        end
      end
    end else begin
      for (int i = 0; i < rcnt; i++) begin
        if (rstarts[i] == blk) begin
          free_sp = free_sp + (ruppers[i] - rhead);
          rhead = ruppers[i];
          rcnt = i;
          return STAT_OK;
        end
      end
    end
    return STAT_NOT_FOUND;
  endfunction

  // Works out the result of one command and advances the predicted state.
  function automatic result_t predict_command(opcode_e op, logic side,
                                              logic [23:0] req, logic [23:0] user);
    result_t r;
    snapshot_t snap;
    r.addr = '0;
    r.status = STAT_OK;
    case (op)
      OP_INIT: pool_init();
      OP_ALLOC: r.status = carve_block(req, side, r.addr);
      OP_FREE: r.status = release_block(user);
      OP_REALLOC: begin
        if (lcnt > 0 && lstarts[lcnt-1] == user - 24'd8) begin
          r.status = release_block(user);
          if (r.status == STAT_OK) r.status = carve_block(req, 1'b0, r.addr);
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      OP_PUSH: begin
        if (scnt >= NSAVE) begin
          r.status = STAT_STACK;
        end else begin
          snap = '{free_sp, lhead, rhead, lcnt, rcnt};
          r.status = carve_block(24'(DEFAULT_STATE_RECORD_BYTES), 1'b0, r.addr);
          if (r.status == STAT_OK) begin
            saved[scnt] = snap;
            scnt++;
          end
        end
      end
      OP_POP: begin
        if (scnt == 0) begin
          r.status = STAT_STACK;
        end else begin
          scnt--;
          free_sp = saved[scnt].free;
          lhead = saved[scnt].lhead;
          rhead = saved[scnt].rhead;
          lcnt = saved[scnt].lcnt;
          rcnt = saved[scnt].rcnt;
        end
      end
      default: ;
    endcase
    r.free = free_sp;
    if (op == OP_AVAIL) r.free = (free_sp >= 24'd8) ? free_sp - 24'd8 : 24'd0;
    return r;
  endfunction

  // Sends one command transaction, sometimes with a random gap ahead of it.
  task automatic issue_cmd(opcode_e op, logic side = 1'b0, logic [23:0] req = '0,
                           logic [23:0] user = '0);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {user, req};
    s_axis_tuser  <= {side, op};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_command(op, side, req, user));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // APB register write; the pool bounds are only taken on the next init.
  task automatic write_pool_reg(cfg_reg_e idx, logic [23:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {8'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_POOL_START) cfg_start = value;
    else cfg_end = value;
  endtask

  task automatic set_pool(logic [23:0] start_addr, logic [23:0] end_addr);
    write_pool_reg(REG_POOL_START, start_addr);
    write_pool_reg(REG_POOL_END, end_addr);
    issue_cmd(OP_INIT);
  endtask

  // Picks the user address of a live block, or a random one when none exist.
  function automatic logic [23:0] live_address(logic side);
    if (!side && lcnt > 0) return lstarts[$urandom_range(lcnt-1)] + 24'd8;
    if (side && rcnt > 0) return rstarts[$urandom_range(rcnt-1)] + 24'd8;
    return 24'($urandom());
  endfunction

  task automatic test_directed();
    logic [23:0] first_left, newest_left;
    issue_cmd(OP_AVAIL);
    issue_cmd(OP_ALLOC, 1'b0, 24'd0);
    first_left = lstarts[lcnt-1] + 24'd8;
    issue_cmd(OP_ALLOC, 1'b1, 24'd1);
    issue_cmd(OP_ALLOC, 1'b0, 24'hFFFFFF);
    issue_cmd(OP_ALLOC, 1'b1, MAX_ROUNDABLE);
    issue_cmd(OP_ALLOC, 1'b0, 24'd100);
    newest_left = lstarts[lcnt-1] + 24'd8;
    issue_cmd(OP_FREE, 1'b0, '0, 24'h123456);
    issue_cmd(OP_REALLOC, 1'b0, 24'd40, lstarts[0] + 24'd8);
    issue_cmd(OP_REALLOC, 1'b0, 24'd300, newest_left);
    issue_cmd(OP_PUSH);
    issue_cmd(OP_ALLOC, 1'b1, 24'd64);
    issue_cmd(OP_POP);
    issue_cmd(OP_POP);
    // Realloc whose free succeeds but whose new allocation fails.
    issue_cmd(OP_REALLOC, 1'b0, 24'hFFFFFF, lstarts[lcnt-1] + 24'd8);
    issue_cmd(OP_NONE, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
    issue_cmd(OP_ALLOC, 1'b0, 24'd16);
    issue_cmd(OP_FREE, 1'b0, '0, first_left);
    issue_cmd(OP_FREE, 1'b1, '0, rstarts[0] + 24'd8);
    issue_cmd(OP_INIT);
  endtask

  // Fills both block tables and the saved-state stack past their limits.
  task automatic test_table_limits();
    for (int i = 0; i <= NBLK; i++) issue_cmd(OP_ALLOC, 1'b1, 24'($urandom_range(32)));
    for (int i = 0; i <= NSAVE; i++) issue_cmd(OP_PUSH);
    for (int i = 0; i < NBLK - NSAVE; i++) issue_cmd(OP_ALLOC, 1'b0, 24'd0);
    issue_cmd(OP_ALLOC, 1'b0, 24'd0);
    issue_cmd(OP_REALLOC, 1'b0, 24'd0, lstarts[lcnt-1] + 24'd8);
    issue_cmd(OP_POP);
    issue_cmd(OP_PUSH);
    issue_cmd(OP_INIT);
    issue_cmd(OP_POP);
  endtask

  // Small, inverted and wrapping pools.
  task automatic test_pool_bounds();
    set_pool(24'h000105, 24'h000400);
    repeat (12) issue_cmd(OP_ALLOC, 1'($urandom()), 24'($urandom_range(64)));
    issue_cmd(OP_AVAIL);
    set_pool(24'h000800, 24'h000010);
    issue_cmd(OP_AVAIL);
    issue_cmd(OP_ALLOC, 1'b0, 24'd0);
    issue_cmd(OP_PUSH);
    set_pool(24'hFFFFFF, 24'h00001F);
    issue_cmd(OP_AVAIL);
    issue_cmd(OP_ALLOC, 1'b0, 24'd0);
    set_pool(24'h000000, 24'hFFFFFF);
    issue_cmd(OP_ALLOC, 1'b0, 24'hFFFFFF);
    issue_cmd(OP_ALLOC, 1'b1, 24'h7FFFF0);
    issue_cmd(OP_AVAIL);
  endtask

  // Mostly well-formed traffic on live blocks, some noise.
  task automatic test_random_traffic(int count, bit hold_off);
    int pick;
    logic side;
    for (int n = 0; n < count; n++) begin
      if (hold_off && n == count / 2) drain_results();
      pick = $urandom_range(99);
      side = 1'($urandom());
      if (pick < 35) begin
        issue_cmd(OP_ALLOC, side, ($urandom_range(9) == 0) ? 24'($urandom())
                                                           : 24'($urandom_range(400)));
      end else if (pick < 55) begin
        issue_cmd(OP_FREE, side, 24'($urandom()),
                  ($urandom_range(9) == 0) ? 24'($urandom()) : live_address(side));
      end else if (pick < 65) begin
        issue_cmd(OP_REALLOC, side, 24'($urandom_range(600)),
                  ($urandom_range(4) != 0 && lcnt > 0) ? lstarts[lcnt-1] + 24'd8
                                                      : live_address(1'b0));
      end else if (pick < 73) begin
        issue_cmd(OP_AVAIL, side, 24'($urandom()), 24'($urandom()));
      end else if (pick < 84) begin
        issue_cmd(OP_PUSH);
      end else if (pick < 95) begin
        issue_cmd(OP_POP);
      end else if (pick < 98) begin
        issue_cmd(OP_INIT);
      end else begin
        issue_cmd(OP_NONE, side, 24'($urandom()), 24'($urandom()));
      end
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no prediction waiting");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[23:0] !== want.addr) begin
          $error("result_address expected %h got %h", want.addr, m_axis_tdata[23:0]);
          failures++;
        end
        if (m_axis_tdata[47:24] !== want.free) begin
          $error("free_bytes expected %h got %h", want.free, m_axis_tdata[47:24]);
          failures++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status expected %0d got %0d", want.status, m_axis_tuser);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    failures = 0;
    quiet_cycles = 0;
    send_idle_pct = 15;
    recv_stall_pct = 46;
    cfg_start = RST_POOL_START;
    cfg_end = RST_POOL_END;
    pool_init();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_table_limits();
    test_pool_bounds();
    set_pool(24'h000000, 24'h100000);
    test_random_traffic(155, 1'b1);
    send_idle_pct = 46;
    recv_stall_pct = 15;
    set_pool(24'($urandom_range(4096)), 24'h00C000 + 24'($urandom_range(4096)));
    test_random_traffic(155, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_pool(24'h000010, 24'hFFFFF0);
    test_random_traffic(155, 1'b0);

    drain_results();
    repeat (80) @(posedge clk_i);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[two_sided_stack_pool_allocator.f]
+incdir+rtl
rtl/tsspa_pkg.sv
rtl/tsspa_ram.sv
rtl/tsspa_cell.sv
rtl/tsspa_chain.sv
rtl/two_sided_stack_pool_allocator.sv
tb/sv/testbench.sv
